[rtl/core/pwm_frequency_duty_meter_core_assert.svh]
// ----------------------------------------------------------------------------
// pwm_frequency_duty_meter_core_assert.svh
// Assertion macros shared by the meter modules.
// ----------------------------------------------------------------------------
`ifndef PWM_FREQUENCY_DUTY_METER_CORE_ASSERT_SVH
`define PWM_FREQUENCY_DUTY_METER_CORE_ASSERT_SVH

// Checked only out of reset.
`define PFDM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PFDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pfdm_pkg.sv]
// ----------------------------------------------------------------------------
// pfdm_pkg
// Types, widths and constants of the PWM frequency and duty meter.
// ----------------------------------------------------------------------------
package pfdm_pkg;

  localparam int unsigned CAP_W      = 16;
  localparam int unsigned FREQ_W     = 28;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned TICK_W     = 24;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 28;

  localparam int unsigned STAMP_BITS_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [FREQ_W-1:0] CLOCK_HZ_RST = FREQ_W'(120000000);
  localparam logic [TICK_W-1:0] TIMEOUT_RST  = TICK_W'(1200000);

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = CFG_IDX_W'(1);

  // Input item kinds
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [CAP_W-1:0] capture_stamp;
    logic             pin_level;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0] duty_percent;
    logic              timed_out;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FREQ,
    BK_DUTY,
    BK_EMIT
  } bk_state_e;

endpackage

[rtl/core/pfdm_front.sv]
// ----------------------------------------------------------------------------
// pfdm_front
// Takes edge and tick items, tracks the measurement and queues result jobs.
// ----------------------------------------------------------------------------
module pfdm_front import pfdm_pkg::*; #(
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF,
  parameter int unsigned JOB_W      = 2 + 2 * STAMP_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_i,
  input  logic [TICK_W-1:0] timeout_i,
  input  logic              full_i,
  output logic              push_o,
  output logic [JOB_W-1:0]  job_o
);

  localparam int unsigned EXT_W = (STAMP_BITS > CAP_W) ? STAMP_BITS : CAP_W;

  logic [1:0]            edges_q;
  logic [TICK_W-1:0]     idle_q;
  logic [STAMP_BITS-1:0] first_q, second_q;
  logic                  laf_q;

  logic                  accept;
  logic [EXT_W-1:0]      stamp_ext;
  logic [STAMP_BITS-1:0] stamp, dlt, per, dsat, high;
  logic [TICK_W-1:0]     tick_n;
  logic                  timed, measure;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign stamp_ext = EXT_W'(in_i.capture_stamp);
  assign stamp     = stamp_ext[STAMP_BITS-1:0];

  // intervals modulo the stamp range, first interval clipped to the period
  assign dlt  = second_q - first_q;
  assign per  = stamp - first_q;
  assign dsat = (dlt > per) ? per : dlt;
  assign high = laf_q ? dsat : (per - dsat);

  assign tick_n  = idle_q + TICK_W'(1);
  assign timed   = (tick_n >= timeout_i);
  assign measure = (edges_q >= 2'd2);

  assign push_o = accept && ((in_i.mode == MODE_TICK) ? timed : measure);
  assign job_o  = (in_i.mode == MODE_TICK)
                ? {1'b1, in_i.pin_level, {(2 * STAMP_BITS){1'b0}}}
                : {1'b0, 1'b0, high, per};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_q <= 2'd0;
      idle_q  <= '0;
    end else if (accept) begin
      if (in_i.mode == MODE_TICK) begin
        if (timed) begin
          edges_q <= 2'd0;
          idle_q  <= '0;
        end else begin
          idle_q  <= tick_n;
        end
      end else begin
        case (edges_q)
          2'd0:    edges_q <= 2'd1;
          2'd1:    edges_q <= 2'd2;
          default: begin
            edges_q <= 2'd0;
            idle_q  <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_i.mode == MODE_EDGE)) begin
      if (edges_q == 2'd0) begin
        first_q <= stamp;
        laf_q   <= in_i.pin_level;
      end
      if (edges_q == 2'd1) begin
        second_q <= stamp;
      end
    end
  end

endmodule

[rtl/core/pfdm_queue.sv]
// ----------------------------------------------------------------------------
// pfdm_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module pfdm_queue import pfdm_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = 2 + 2 * STAMP_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

`include "pwm_frequency_duty_meter_core_assert.svh"

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  `PFDM_ASSERT(a_no_pop_empty, clk_i, rst_ni, empty_o |-> !pop_i, "pop from empty queue")
  `PFDM_ASSERT(a_no_push_full, clk_i, rst_ni, full_o |-> !push_i, "push into full queue")

endmodule

[rtl/core/pfdm_back.sv]
// ----------------------------------------------------------------------------
// pfdm_back
// Works out frequency and duty with a shared serial divider; output register.
// ----------------------------------------------------------------------------
module pfdm_back import pfdm_pkg::*; #(
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF,
  parameter int unsigned JOB_W      = 2 + 2 * STAMP_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FREQ_W-1:0] clock_hz_i,
  input  logic              empty_i,
  input  logic [JOB_W-1:0]  job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_o
);

`include "pwm_frequency_duty_meter_core_assert.svh"

  localparam int unsigned SB    = STAMP_BITS;
  localparam int unsigned DW    = (SB + DUTY_W > FREQ_W) ? SB + DUTY_W : FREQ_W;
  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam logic [DW-1:0] SCALE = DW'(DUTY_FULL);

  bk_state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q;
  logic [DW-1:0]     dvd_q, dvd_d;
  logic [SB-1:0]     rem_q, rem_d, p_q, high_q;
  logic [SB:0]       trial;
  logic              ge;
  logic [FREQ_W-1:0] freq_q;
  logic [DUTY_W-1:0] duty_q;
  logic              to_q;
  logic              load_out;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              job_to, job_lvl;
  logic [SB-1:0]     job_high, job_p;

  assign job_to   = job_i[JOB_W-1];
  assign job_lvl  = job_i[JOB_W-2];
  assign job_high = job_i[2*SB-1:SB];
  assign job_p    = job_i[SB-1:0];

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[DW-1]};
  assign ge    = (trial >= {1'b0, p_q});
  assign rem_d = ge ? SB'(trial - {1'b0, p_q}) : trial[SB-1:0];
  assign dvd_d = {dvd_q[DW-2:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = (job_to || (job_p == '0)) ? BK_EMIT : BK_FREQ;
        end
      end
      BK_FREQ: if (cnt_q == CNT_W'(1)) state_d = BK_DUTY;
      BK_DUTY: if (cnt_q == CNT_W'(1)) state_d = BK_EMIT;
      BK_EMIT: if (load_out) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: pop_o    = !empty_i;
      BK_EMIT: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BK_IDLE: if (pop_o) cnt_q <= CNT_W'(DW);
        BK_FREQ: cnt_q <= (cnt_q == CNT_W'(1)) ? CNT_W'(DW) : cnt_q - CNT_W'(1);
        BK_DUTY: cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          p_q    <= job_p;
          high_q <= job_high;
          dvd_q  <= DW'(clock_hz_i);
          rem_q  <= '0;
          to_q   <= job_to;
          freq_q <= '0;
          duty_q <= (job_to && job_lvl) ? DUTY_FULL : '0;
        end
      end
      BK_FREQ: begin
        if (cnt_q == CNT_W'(1)) begin
          freq_q <= dvd_d[FREQ_W-1:0];
          dvd_q  <= DW'(high_q) * SCALE;
          rem_q  <= '0;
        end else begin
          dvd_q <= dvd_d;
          rem_q <= rem_d;
        end
      end
      BK_DUTY: begin
        dvd_q <= dvd_d;
        rem_q <= rem_d;
        if (cnt_q == CNT_W'(1)) begin
          duty_q <= dvd_d[DUTY_W-1:0];
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_q <= '{freq_hz: freq_q, duty_percent: duty_q, timed_out: to_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `PFDM_ASSERT(a_div_count, clk_i, rst_ni,
    (state_q == BK_FREQ || state_q == BK_DUTY) |-> cnt_q != '0, "divider count ran out")
  `PFDM_ASSERT(a_duty_range, clk_i, rst_ni,
    (state_q == BK_EMIT) |-> duty_q <= DUTY_FULL, "duty above full scale")
  `PFDM_ASSERT(a_timeout_zero, clk_i, rst_ni,
    (out_valid_o && out_o.timed_out) |-> out_o.freq_hz == '0, "timeout with nonzero frequency")
  `PFDM_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_q, "result valid in reset")

endmodule

[rtl/core/pwm_frequency_duty_meter_core.sv]
// ----------------------------------------------------------------------------
// pwm_frequency_duty_meter_core
// Input-capture frequency and duty meter: edge and tick items in, results out.
// ----------------------------------------------------------------------------
// Use:
//   in channel : one item per handshake. mode = edge carries the capture
//                stamp and the pin level; mode = tick counts idle time.
//   out channel: one result per completed three-capture measurement, or per timeout tick.
//   cfg channel: index 0 = clock_hz, index 1 = timeout_ticks, always ready;
//                the user writes only while idle; not enforced by the block.
// Throughput: the front takes one item every cycle while the job queue has
//   room; when the queue is full, in_ready drops for every item kind. The
//   back takes a new job only after the last result is in the output
//   register; measurements go through the bit-serial divider, DW bits wide
//   (DW = max(28, STAMP_BITS+7), 28 at the default), shared by frequency
//   and duty, while timeout and zero-period jobs skip the divider.
// Stall: results wait in the output register; the back waits to unload it,
//   the queue fills behind it and then in_ready drops.
// Reset: measurement and idle count cleared, queue empty, no result pending,
//   registers back to 120 MHz and 1200000 ticks.
// ----------------------------------------------------------------------------
module pwm_frequency_duty_meter_core import pfdm_pkg::*; #(
  parameter int unsigned STAMP_BITS  = STAMP_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // job: timeout flag, pin level, high time, period
  localparam int unsigned JOB_W = 2 + 2 * STAMP_BITS;

  logic [FREQ_W-1:0] clock_hz_q;
  logic [TICK_W-1:0] timeout_q;

  logic             push, pop, full, empty;
  logic [JOB_W-1:0] job_wr, job_rd;

  // Configuration registers; writes outside the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CLOCK_HZ: clock_hz_q <= cfg_data_i[FREQ_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: classifies items and keeps the partial measurement
  pfdm_front #(
    .STAMP_BITS (STAMP_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .timeout_i  (timeout_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_wr)
  );

  // Decoupling queue, keeps results in order
  pfdm_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_wr),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (job_rd),
    .empty_o (empty)
  );

  // Back: divisions and the output register
  pfdm_back #(
    .STAMP_BITS (STAMP_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clock_hz_i  (clock_hz_q),
    .empty_i     (empty),
    .job_i       (job_rd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

[tb/pwm_frequency_duty_meter_core_tb.sv]
// ----------------------------------------------------------------------------
// pwm_frequency_duty_meter_core_tb
// Self-checking bench for the frequency and duty meter. Edge and tick items
// are driven with random gaps and random output back-pressure. Each accepted
// item is fed to a cycle-free model of the meter, and each reading the block
// gives is compared field by field with the oldest reading still awaited.
// ----------------------------------------------------------------------------
module pwm_frequency_duty_meter_core_tb import pfdm_pkg::*; ();

  localparam int unsigned SETTLE_CYCLES    = 200;
  localparam int unsigned RUN_LIMIT_CYCLES = 2000000;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned PHASE_ITEMS      = 225;
  localparam int unsigned MAX_REPORTS      = 100;
  localparam int unsigned IN_W             = $bits(in_item_t);

  // Index that maps to no register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE   = CFG_IDX_W'(8'hFF);
  localparam logic [FREQ_W-1:0]     CLOCK_TOP   = '1;
  localparam logic [TICK_W-1:0]     TIMEOUT_TOP = '1;

  // --------------------------------------------------------------------------
  // Reading tracker: follows the meter's state item by item and keeps the
  // readings that the block still owes, oldest first.
  // --------------------------------------------------------------------------
  class meter_scoreboard;
    logic [FREQ_W-1:0] clock_hz;
    logic [TICK_W-1:0] timeout_ticks;
    logic [1:0]        edge_count;
    logic [CAP_W-1:0]  first_stamp;
    logic [CAP_W-1:0]  second_stamp;
    logic              first_level;
    logic [TICK_W-1:0] idle_count;
    out_item_t         awaited[$];
    int unsigned       mismatches;

    function new();
      clock_hz      = CLOCK_HZ_RST;
      timeout_ticks = TIMEOUT_RST;
      edge_count    = '0;
      first_stamp   = '0;
      second_stamp  = '0;
      first_level   = 1'b0;
      idle_count    = '0;
      mismatches    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CLOCK_HZ) begin
        clock_hz = data[FREQ_W-1:0];
      end else if (idx == CFG_TIMEOUT) begin
        timeout_ticks = data[TICK_W-1:0];
      end
    endfunction

    // Accepted item in; a reading is queued when the item completes one
    function void note_item(in_item_t it);
      out_item_t        reading;
      logic [CAP_W-1:0] span;
      logic [CAP_W-1:0] period;
      logic [31:0]      high_time;
      reading = '0;
      if (it.mode == MODE_TICK) begin
        idle_count = idle_count + 1'b1;
        if (idle_count < timeout_ticks) return;
        // static pin: level decides 0 or full duty
        reading.duty_percent = it.pin_level ? DUTY_FULL : '0;
        reading.timed_out    = 1'b1;
      end else if (edge_count == 2'd0) begin
        first_stamp = it.capture_stamp;
        first_level = it.pin_level;
        edge_count  = 2'd1;
        return;
      end else if (edge_count == 2'd1) begin
        second_stamp = it.capture_stamp;
        edge_count   = 2'd2;
        return;
      end else begin
        // intervals wrap with the free-running timer
        span   = second_stamp - first_stamp;
        period = it.capture_stamp - first_stamp;
        if (period != '0) begin
          if (span > period) span = period;
          high_time            = 32'(first_level ? span : period - span);
          reading.freq_hz      = clock_hz / period;
          reading.duty_percent = DUTY_W'(high_time * 100 / period);
        end
      end
      awaited.push_back(reading);
      edge_count = '0;
      idle_count = '0;
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      mismatches++;
      // keep the log readable on a runaway
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report("unexpected reading, freq_hz", 0, got.freq_hz);
        return;
      end
      want = awaited.pop_front();
      if (got.freq_hz !== want.freq_hz)
        report("freq_hz", want.freq_hz, got.freq_hz);
      if (got.duty_percent !== want.duty_percent)
        report("duty_percent", want.duty_percent, got.duty_percent);
      if (got.timed_out !== want.timed_out)
        report("timed_out", want.timed_out, got.timed_out);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  meter_scoreboard sb = new();
  int unsigned     items_sent;
  int unsigned     burst_left;

  pwm_frequency_duty_meter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_CYCLES * 12);
    $display("FAILED: results differ");
    $finish;
  end

  // Readings are taken at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_o);
  end

  // Output back-pressure: mostly short stalls, a few long ones, and now and
  // then a long stretch with ready held high.
  initial begin
    int unsigned run;
    int unsigned stall;
    int unsigned roll;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run   = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 10);
      roll  = $urandom_range(0, 99);
      stall = (roll < 60) ? $urandom_range(1, 2) :
              (roll < 90) ? $urandom_range(3, 8) : $urandom_range(20, 60);
      @(negedge clk_i);
      out_ready_i = 1'b1;
      repeat (run) @(negedge clk_i);
      out_ready_i = 1'b0;
      repeat (stall - 1) @(negedge clk_i);
    end
  end

  function automatic logic [CAP_W-1:0] rand_stamp();
    return CAP_W'($urandom);
  endfunction

  function automatic logic rand_level();
    return 1'($urandom_range(0, 1));
  endfunction

  // Sender gap before the next item; bursts give runs of back-to-back items
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one item; valid stays high across back-to-back items
  task automatic send_item(logic mode, logic [CAP_W-1:0] stamp, logic level);
    in_item_t    it;
    int unsigned gap;
    it.mode          = mode;
    it.capture_stamp = stamp;
    it.pin_level     = level;
    gap              = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      in_i       = IN_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_i       = it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Stop sending, wait for every owed reading, then let the back end drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_item(MODE_TICK, rand_stamp(), rand_level());
  endtask

  // Three well-formed edges with random period and high time
  task automatic send_measurement();
    logic [CAP_W-1:0] start;
    logic [CAP_W-1:0] span;
    logic [CAP_W-1:0] period;
    int unsigned      roll;
    start = rand_stamp();
    roll  = $urandom_range(0, 99);
    if (roll < 40)      period = CAP_W'($urandom_range(1, 400));
    else if (roll < 88) period = rand_stamp();
    else if (roll < 94) period = '0;
    else                period = '1;
    // now and then the second capture lands past the third
    if ($urandom_range(0, 9) == 0) span = rand_stamp();
    else                           span = CAP_W'($urandom_range(0, period));
    send_item(MODE_EDGE, start, rand_level());
    maybe_ticks();
    send_item(MODE_EDGE, start + span, rand_level());
    maybe_ticks();
    send_item(MODE_EDGE, start + period, rand_level());
  endtask

  // Noise: tick runs, stray edges and measurements cut short by ticks
  task automatic send_noise();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      repeat ($urandom_range(1, 40)) send_item(MODE_TICK, rand_stamp(), rand_level());
    end else if (roll < 80) begin
      send_item(MODE_EDGE, rand_stamp(), rand_level());
    end else begin
      send_item(MODE_EDGE, rand_stamp(), rand_level());
      send_item(MODE_EDGE, rand_stamp(), rand_level());
      repeat ($urandom_range(1, 20)) send_item(MODE_TICK, rand_stamp(), rand_level());
    end
  endtask

  initial begin
    logic [FREQ_W-1:0] clock_sel;
    logic [TICK_W-1:0] timeout_sel;
    int unsigned       phase_end;
    items_sent  = 0;
    burst_left  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed part, reset register values ----
    // full-scale period, about half high
    send_item(MODE_EDGE, 16'h0000, 1'b1);
    send_item(MODE_EDGE, 16'h8000, 1'b0);
    send_item(MODE_EDGE, 16'hFFFF, 1'b1);
    // zero period
    send_item(MODE_EDGE, 16'h1234, 1'b0);
    send_item(MODE_EDGE, 16'h1240, 1'b1);
    send_item(MODE_EDGE, 16'h1234, 1'b0);
    // second capture beyond the third: high time saturates to the period
    send_item(MODE_EDGE, 16'd100, 1'b1);
    send_item(MODE_EDGE, 16'd500, 1'b0);
    send_item(MODE_EDGE, 16'd300, 1'b1);
    // low after the first edge, stamps wrapping through zero
    send_item(MODE_EDGE, 16'hFFF0, 1'b0);
    send_item(MODE_EDGE, 16'h0005, 1'b1);
    send_item(MODE_EDGE, 16'h0010, 1'b0);
    // one-count period, no high time
    send_item(MODE_EDGE, 16'd7, 1'b1);
    send_item(MODE_EDGE, 16'd7, 1'b0);
    send_item(MODE_EDGE, 16'd8, 1'b1);
    send_item(MODE_TICK, 16'hFFFF, 1'b1);

    // zero timeout, written with bits above the register width set
    settle();
    write_reg(CFG_TIMEOUT, 28'hF00_0000);
    send_item(MODE_TICK, 16'h0000, 1'b0);
    send_item(MODE_TICK, 16'h5A5A, 1'b1);
    // a tick between edges drops the partial measurement
    send_item(MODE_EDGE, 16'd10, 1'b1);
    send_item(MODE_TICK, 16'd0, 1'b1);
    send_item(MODE_EDGE, 16'd20, 1'b1);
    send_item(MODE_EDGE, 16'd30, 1'b0);
    send_item(MODE_EDGE, 16'd40, 1'b0);

    // zero clock; a write to the spare index changes nothing
    settle();
    write_reg(CFG_CLOCK_HZ, '0);
    write_reg(CFG_SPARE, '1);
    send_item(MODE_EDGE, 16'd0, 1'b1);
    send_item(MODE_EDGE, 16'd3, 1'b1);
    send_item(MODE_EDGE, 16'd9, 1'b0);

    // ---- random phases, each with its own register setting ----
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0:       clock_sel = FREQ_W'(1);
        1:       clock_sel = FREQ_W'(200000000);
        2:       clock_sel = CLOCK_TOP;
        default: clock_sel = FREQ_W'($urandom_range(1, 200000000));
      endcase
      case (phase % 3)
        0:       timeout_sel = TICK_W'($urandom_range(8, 60));
        1:       timeout_sel = TICK_W'(1);
        default: timeout_sel = TIMEOUT_TOP;
      endcase
      settle();
      write_reg(CFG_TIMEOUT, CFG_DATA_W'(timeout_sel));
      write_reg(CFG_CLOCK_HZ, CFG_DATA_W'(clock_sel));
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 85) send_measurement();
        else                            send_noise();
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/pfdm_pkg.sv
rtl/core/pfdm_front.sv
rtl/core/pfdm_queue.sv
rtl/core/pfdm_back.sv
rtl/core/pwm_frequency_duty_meter_core.sv
tb/pwm_frequency_duty_meter_core_tb.sv
